// File: design/protobuf_wire_field_tokenizer_top_macros.svh
// Assertion macros for the protobuf field tokenizer.
// Each macro expands to a clocked concurrent assertion on clk, disabled while rst_n is low.
`ifndef PROTOBUF_WIRE_FIELD_TOKENIZER_TOP_MACROS_SVH
`define PROTOBUF_WIRE_FIELD_TOKENIZER_TOP_MACROS_SVH
`ifndef SYNTH
`define PBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PBT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PBT_ASSERT(lbl, prop, msg)
`define PBT_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// File: design/pbt_pkg.sv
// Shared types and codes for the protobuf field tokenizer.
// No dependencies.
package pbt_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO_KEY = 3'd1,
    ST_BAD_WIRE = 3'd2,
    ST_OVERLONG = 3'd3,
    ST_TRUNC    = 3'd4
  } status_t;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_I64    = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_I32    = 3'd5;

  localparam logic [3:0] VARINT_LAST_IDX = 4'd9;
  localparam logic [3:0] FIX64_BYTES    = 4'd8;
  localparam logic [3:0] FIX32_BYTES    = 4'd4;

  typedef enum logic [4:0] {
    PH_KEY   = 5'b00001,
    PH_VALUE = 5'b00010,
    PH_LEN   = 5'b00100,
    PH_SKIP  = 5'b01000,
    PH_HALT  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] field_number;
    logic [2:0]  wire_type;
    logic [63:0] varint_value;
    logic [11:0] payload_offset;
    logic [12:0] payload_length;
    logic        end_of_message;
  } out_item_t;

  // Per-byte varint decode flags
  typedef struct packed {
    logic done;
    logic overlong;
  } vint_flags_t;

endpackage

// File: design/pbt_stream_if.sv
// Valid/ready stream interface for the protobuf field tokenizer.
// Payload type is supplied by the instantiating scope.
interface pbt_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: design/pbt_varint.sv
// Varint byte merge: ORs seven payload bits into the accumulator at the current group.
// Depends on pbt_pkg.
module pbt_varint import pbt_pkg::*; (
  input  logic [63:0] acc,
  input  logic [3:0]  group_idx,
  input  logic [7:0]  data_byte,
  output logic [63:0] merged,
  output logic [3:0]  group_inc,
  output vint_flags_t flags
);

  logic [6:0] bit_ofs;

  // group * 7, at most 63
  assign bit_ofs   = {group_idx, 3'b000} - {3'b000, group_idx};
  assign merged    = acc | (64'(data_byte[6:0]) << bit_ofs[5:0]);
  assign group_inc = group_idx + 4'd1;

  always_comb begin
    flags.done     = !data_byte[7];
    flags.overlong = data_byte[7] && (group_idx >= VARINT_LAST_IDX);
  end

endmodule

// File: design/pbt_parse.sv
// Field parser: parse state, per-byte decision logic and the result register.
// Depends on pbt_pkg, pbt_varint and the assertion macro header.
`include "protobuf_wire_field_tokenizer_top_macros.svh"
module pbt_parse import pbt_pkg::*; #(
  parameter int BUFFER_BYTES = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  in_item_t  q_word,
  output logic      take,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_word
);

  localparam int POS_W = $clog2(BUFFER_BYTES + 1);

  phase_t            phase_r, phase_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic [3:0]        grp_r, grp_nxt;
  logic [31:0]       num_r, num_nxt;
  logic [2:0]        wire_r, wire_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  skip_r, skip_nxt;
  logic [11:0]       start_r, start_nxt;
  logic              out_valid_r;
  out_item_t         out_word_r;

  logic [63:0]       merged;
  logic [3:0]        grp_inc;
  vint_flags_t       vf;
  logic [31:0]       pos_inc;
  logic [31:0]       room;
  logic              len_too_big;
  logic [POS_W-1:0]  skip_dec;
  logic              emit;
  out_item_t         res;
  logic              do_fail;
  status_t           f_status;
  logic [31:0]       f_num;
  logic [2:0]        f_wire;
  logic              last;

  pbt_varint u_varint (
    .acc       (acc_r),
    .group_idx (grp_r),
    .data_byte (q_word.data_byte),
    .merged    (merged),
    .group_inc (grp_inc),
    .flags     (vf)
  );

  assign last     = q_word.last_byte;
  assign take     = q_valid && (!out_valid_r || out_ready);
  assign pos_inc  = 32'(pos_r) + 32'd1;
  assign room     = (pos_inc >= 32'(BUFFER_BYTES)) ? 32'd0 : 32'(BUFFER_BYTES) - pos_inc;
  assign len_too_big = (|merged[63:32]) || (merged[31:0] > room);
  assign skip_dec = (skip_r != '0) ? skip_r - POS_W'(1) : skip_r;

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    grp_nxt   = grp_r;
    num_nxt   = num_r;
    wire_nxt  = wire_r;
    skip_nxt  = skip_r;
    start_nxt = start_r;
    emit      = 1'b0;
    res       = '0;
    do_fail   = 1'b0;
    f_status  = ST_TRUNC;
    f_num     = num_r;
    f_wire    = wire_r;

    // saturate inside an overlong buffer, restart at the next buffer
    if (last) begin
      pos_nxt = '0;
    end else if (pos_r != POS_W'(BUFFER_BYTES)) begin
      pos_nxt = pos_r + POS_W'(1);
    end else begin
      pos_nxt = pos_r;
    end

    case (phase_r)
      PH_KEY: begin
        f_num  = 32'd0;
        f_wire = 3'd0;
        if (vf.overlong) begin
          do_fail  = 1'b1;
          f_status = ST_OVERLONG;
        end else if (!vf.done) begin
          acc_nxt = merged;
          grp_nxt = grp_inc;
          if (last) begin
            do_fail = 1'b1;
          end
        end else begin
          acc_nxt = '0;
          grp_nxt = '0;
          if (merged == 64'd0) begin
            do_fail  = 1'b1;
            f_status = ST_ZERO_KEY;
          end else begin
            num_nxt = merged[34:3];
            wire_nxt = merged[2:0];
            f_num   = merged[34:3];
            f_wire  = merged[2:0];
            case (merged[2:0])
              WT_VARINT: begin
                if (last) do_fail = 1'b1;
                else phase_nxt = PH_VALUE;
              end
              WT_LEN: begin
                if (last) do_fail = 1'b1;
                else phase_nxt = PH_LEN;
              end
              WT_I64, WT_I32: begin
                acc_nxt = (merged[2:0] == WT_I64) ? 64'(FIX64_BYTES) : 64'(FIX32_BYTES);
                if (last || (acc_nxt[31:0] > room)) begin
                  do_fail = 1'b1;
                end else begin
                  start_nxt = pos_inc[11:0];
                  skip_nxt  = POS_W'(acc_nxt[3:0]);
                  phase_nxt = PH_SKIP;
                end
              end
              default: begin
                do_fail  = 1'b1;
                f_status = ST_BAD_WIRE;
              end
            endcase
          end
        end
      end
      PH_VALUE: begin
        if (vf.overlong) begin
          do_fail  = 1'b1;
          f_status = ST_OVERLONG;
        end else if (!vf.done) begin
          acc_nxt = merged;
          grp_nxt = grp_inc;
          if (last) do_fail = 1'b1;
        end else begin
          phase_nxt = PH_KEY;
          emit      = 1'b1;
          res       = '{status: ST_OK, field_number: num_r, wire_type: wire_r,
                        varint_value: merged, payload_offset: 12'd0,
                        payload_length: 13'd0, end_of_message: last};
          acc_nxt   = '0;
          grp_nxt   = '0;
        end
      end
      PH_LEN: begin
        if (vf.overlong) begin
          do_fail  = 1'b1;
          f_status = ST_OVERLONG;
        end else if (!vf.done) begin
          acc_nxt = merged;
          grp_nxt = grp_inc;
          if (last) do_fail = 1'b1;
        end else if (len_too_big) begin
          do_fail = 1'b1;
        end else if (merged == 64'd0) begin
          phase_nxt = PH_KEY;
          acc_nxt   = '0;
          grp_nxt   = '0;
          emit      = 1'b1;
          res       = '{status: ST_OK, field_number: num_r, wire_type: wire_r,
                        varint_value: 64'd0, payload_offset: pos_inc[11:0],
                        payload_length: 13'd0, end_of_message: last};
        end else if (last) begin
          do_fail = 1'b1;
        end else begin
          // keep the length in the accumulator for the final report
          acc_nxt   = merged;
          start_nxt = pos_inc[11:0];
          skip_nxt  = merged[POS_W-1:0];
          phase_nxt = PH_SKIP;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = PH_KEY;
          emit      = 1'b1;
          res       = '{status: ST_OK, field_number: num_r, wire_type: wire_r,
                        varint_value: 64'd0, payload_offset: start_r,
                        payload_length: acc_r[12:0], end_of_message: last};
          acc_nxt   = '0;
          grp_nxt   = '0;
        end else if (last) begin
          do_fail = 1'b1;
        end
      end
      PH_HALT: begin
        if (last) phase_nxt = PH_KEY;
      end
      default: begin
        phase_nxt = PH_KEY;
      end
    endcase

    if (do_fail) begin
      phase_nxt = last ? PH_KEY : PH_HALT;
      acc_nxt   = '0;
      grp_nxt   = '0;
      skip_nxt  = '0;
      emit      = 1'b1;
      res       = '{status: f_status, field_number: f_num, wire_type: f_wire,
                    varint_value: 64'd0, payload_offset: 12'd0,
                    payload_length: 13'd0, end_of_message: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_KEY;
      acc_r       <= '0;
      grp_r       <= '0;
      num_r       <= '0;
      wire_r      <= '0;
      pos_r       <= '0;
      skip_r      <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        grp_r   <= grp_nxt;
        num_r   <= num_nxt;
        wire_r  <= wire_nxt;
        pos_r   <= pos_nxt;
        skip_r  <= skip_nxt;
        start_r <= start_nxt;
      end
      if (take && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `PBT_ASSERT(a_err_halts, take && emit && (res.status != ST_OK) && !last |=> phase_r == PH_HALT, "error did not halt parser")
  `PBT_ASSERT_NEVER(a_skip_nonzero, (phase_r == PH_SKIP) && (skip_r == '0), "skip phase with zero count")
  `PBT_ASSERT(a_last_rewinds, take && last |=> pos_r == '0, "position not rewound at buffer end")
  `PBT_ASSERT_NEVER(a_halt_silent, take && (phase_r == PH_HALT) && emit, "result emitted while halted")

endmodule

// File: design/protobuf_wire_field_tokenizer_top.sv
// Protobuf wire-format field tokenizer, top level.
// Depends on pbt_pkg, pbt_stream_if and pbt_parse.
//
// Usage:
//   in_ch carries one buffer byte per word (data_byte, last_byte); last_byte
//   closes the buffer and the next word starts a new one at index 0.
//   out_ch carries one result word per completed field, and one per error,
//   with end_of_message set on the last byte of a buffer and on every error.
//   After an error, bytes are dropped silently up to the next last_byte.
// Timing:
//   One byte per cycle sustained while out_ch does not stall. Each byte is
//   registered in the input register, then its result in the output register,
//   which drives out_ch.valid; the parser takes a byte only when the output
//   register has room. Bytes that close no field produce no word.
// Stall:
//   While a result waits on out_ch, the parser takes no byte from the input
//   register, and in_ch.ready stays high only while that register is empty.
// Reset:
//   rst_n low (synchronous) empties both registers and returns the parser to
//   waiting for a key at buffer index 0.
module protobuf_wire_field_tokenizer_top import pbt_pkg::*; #(
  parameter int BUFFER_BYTES = 4096
) (
  input  logic         clk,
  input  logic         rst_n,
  pbt_stream_if.sink   in_ch,
  pbt_stream_if.source out_ch
);

  logic      q_valid_r;
  in_item_t  q_word_r;
  logic      take;
  logic      out_valid;
  out_item_t out_word;

  assign in_ch.ready = !q_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      q_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      q_word_r <= in_ch.payload;
    end
  end

  pbt_parse #(.BUFFER_BYTES(BUFFER_BYTES)) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid_r),
    .q_word    (q_word_r),
    .take      (take),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_word;

endmodule
